FILE: hw/rtl/generational_handle_allocator_unit_macros.svh
// Assertion macros used by the handle allocator top level.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gha_pkg.sv
// Shared types and constants of the generational handle allocator.
package gha_pkg;

  localparam int HANDLE_W  = 26;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 3;

  localparam int INDEX_BITS_DEF      = 10;
  localparam int GENERATION_BITS_DEF = 16;
  localparam int PAYLOAD_BITS_DEF    = 32;

  localparam logic ACT_OPEN  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OPENED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_CLOSED    = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_STALE     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Decision for one transaction, handed from the decision logic to the top level.
  typedef struct packed {
    status_t status;
    logic    slot_we;
    logic    append;
    logic    pop;
    logic    push;
  } ctl_t;

endpackage

FILE: hw/rtl/gha_if.sv
// Valid/ready channel interfaces for requests and responses.
interface gha_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [gha_pkg::PAYLOAD_W-1:0] payload;
  logic [gha_pkg::HANDLE_W-1:0]  handle_in;

  modport source (output valid, action, payload, handle_in, input ready);
  modport sink (input valid, action, payload, handle_in, output ready);
endinterface

interface gha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gha_pkg::HANDLE_W-1:0] handle_out;
  logic [gha_pkg::STATUS_W-1:0] status;

  modport source (output valid, handle_out, status, input ready);
  modport sink (input valid, handle_out, status, output ready);
endinterface

FILE: hw/rtl/gha_ram.sv
// Generic simple dual-port RAM with a registered read.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/gha_decide.sv
// Decision logic: classifies an open or close and picks the slot and generation.
module gha_decide #(
  parameter int INDEX_BITS      = gha_pkg::INDEX_BITS_DEF,
  parameter int GENERATION_BITS = gha_pkg::GENERATION_BITS_DEF
) (
  input  logic                       action,
  input  logic [INDEX_BITS-1:0]      op_idx,
  input  logic [GENERATION_BITS-1:0] op_gen,
  input  logic [INDEX_BITS-1:0]      slot_count,
  input  logic [INDEX_BITS-1:0]      free_head,
  input  logic                       rd_live,
  input  logic [GENERATION_BITS-1:0] rd_gen,
  output gha_pkg::ctl_t              ctl,
  output logic [INDEX_BITS-1:0]      wr_idx,
  output logic [GENERATION_BITS-1:0] wr_gen
);

  localparam logic [INDEX_BITS-1:0] INVALID = {INDEX_BITS{1'b1}};
  localparam logic [GENERATION_BITS-1:0] GEN_ONE = GENERATION_BITS'(1);

  logic                       head_empty;
  logic [GENERATION_BITS-1:0] bumped;

  assign head_empty = (free_head == INVALID);
  assign bumped     = op_gen + GEN_ONE;

  always_comb begin
    ctl         = '0;
    ctl.status  = gha_pkg::ST_OPENED;
    wr_idx      = op_idx;
    wr_gen      = GEN_ONE;
    if (action == gha_pkg::ACT_OPEN) begin
      if (head_empty) begin
        wr_idx = slot_count;
        wr_gen = GEN_ONE;
        if (slot_count == INVALID) begin
          ctl.status = gha_pkg::ST_FULL;
        end else begin
          ctl.append  = 1'b1;
          ctl.slot_we = 1'b1;
        end
      end else begin
        wr_idx      = free_head;
        wr_gen      = rd_gen;
        ctl.pop     = 1'b1;
        ctl.slot_we = 1'b1;
      end
    end else begin
      // The generation advances on every successful close and never lands on zero.
      wr_gen = (bumped == '0) ? GEN_ONE : bumped;
      if (op_idx >= slot_count) begin
        ctl.status = gha_pkg::ST_BAD_INDEX;
      end else if (!rd_live || (op_gen != rd_gen)) begin
        ctl.status = gha_pkg::ST_STALE;
      end else begin
        ctl.status  = gha_pkg::ST_CLOSED;
        ctl.push    = 1'b1;
        ctl.slot_we = 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/generational_handle_allocator_unit.sv
// Top level of the generational handle allocator with a FIFO free list.
//
//   Channel   Role   Transaction carries
//   req       sink   action, payload, handle_in
//   rsp       source handle_out, status
//
// A request is accepted, then committed: the accepting edge launches the slot-table and
// link-table reads, and the edge that leaves the execute state commits the decision,
// writes the tables back and loads the response register. That read-modify-write of one
// slot per request lets no new request in until the last has committed. The commit is held
// while the response register is still full and not being taken. Reset clears the slot
// count, the free-list head and tail and the response valid flag; the tables need no clearing.
module generational_handle_allocator_unit #(
  parameter int INDEX_BITS      = gha_pkg::INDEX_BITS_DEF,
  parameter int GENERATION_BITS = gha_pkg::GENERATION_BITS_DEF,
  parameter int PAYLOAD_BITS    = gha_pkg::PAYLOAD_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  gha_req_if.sink  req,
  gha_rsp_if.source rsp
);

`include "generational_handle_allocator_unit_macros.svh"

  localparam int DEPTH   = 1 << INDEX_BITS;
  localparam int SLOT_W  = 1 + GENERATION_BITS + PAYLOAD_BITS;
  localparam int HEXT_W  = INDEX_BITS + GENERATION_BITS + gha_pkg::HANDLE_W;
  localparam int PEXT_W  = PAYLOAD_BITS + gha_pkg::PAYLOAD_W;
  localparam logic [INDEX_BITS-1:0] INVALID = {INDEX_BITS{1'b1}};

  // Control state.
  gha_pkg::state_t state;
  gha_pkg::state_t state_next;
  logic [INDEX_BITS-1:0] slot_count;
  logic [INDEX_BITS-1:0] free_head;
  logic [INDEX_BITS-1:0] free_tail;
  logic                  out_valid;

  // Request held during the execute cycle.
  logic                       op_action;
  logic [PAYLOAD_BITS-1:0]    op_payload;
  logic [INDEX_BITS-1:0]      op_idx;
  logic [GENERATION_BITS-1:0] op_gen;

  // Response register.
  logic [gha_pkg::HANDLE_W-1:0] out_handle;
  gha_pkg::status_t             out_status;

  logic accept;
  logic exec_go;

  // The incoming handle is widened so that the index and generation fields can
  // be picked out for any split of the bits; missing high bits read as zero.
  logic [HEXT_W-1:0]          req_hext;
  logic [INDEX_BITS-1:0]      req_idx;
  logic [GENERATION_BITS-1:0] req_gen;
  logic [PEXT_W-1:0]          req_pext;

  assign req_hext = {{(INDEX_BITS + GENERATION_BITS){1'b0}}, req.handle_in};
  assign req_idx  = req_hext[INDEX_BITS-1:0];
  assign req_gen  = req_hext[INDEX_BITS +: GENERATION_BITS];
  assign req_pext = {{PAYLOAD_BITS{1'b0}}, req.payload};

  // Slot table holds {live, generation, payload}; the link table holds the
  // free-list successor of each freed slot.
  logic                  slot_re;
  logic [INDEX_BITS-1:0] slot_raddr;
  logic [SLOT_W-1:0]     slot_rdata;
  logic                  slot_we;
  logic [INDEX_BITS-1:0] slot_waddr;
  logic [SLOT_W-1:0]     slot_wdata;
  logic                  link_we;
  logic [INDEX_BITS-1:0] link_rdata;

  logic                       rd_live;
  logic [GENERATION_BITS-1:0] rd_gen;

  assign rd_live = slot_rdata[SLOT_W-1];
  assign rd_gen  = slot_rdata[PAYLOAD_BITS +: GENERATION_BITS];

  gha_pkg::ctl_t              ctl;
  logic [INDEX_BITS-1:0]      wr_idx;
  logic [GENERATION_BITS-1:0] wr_gen;
  logic [HEXT_W-1:0]          new_hext;
  logic [INDEX_BITS-1:0]      pop_head;

  gha_decide #(
    .INDEX_BITS      (INDEX_BITS),
    .GENERATION_BITS (GENERATION_BITS)
  ) u_decide (
    .action     (op_action),
    .op_idx     (op_idx),
    .op_gen     (op_gen),
    .slot_count (slot_count),
    .free_head  (free_head),
    .rd_live    (rd_live),
    .rd_gen     (rd_gen),
    .ctl        (ctl),
    .wr_idx     (wr_idx),
    .wr_gen     (wr_gen)
  );

  gha_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gha_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (free_tail),
    .wdata (op_idx),
    .re    (slot_re),
    .raddr (free_head),
    .rdata (link_rdata)
  );

  // Handshake: outside reset, a new request is taken whenever no request is in its
  // execute cycle, even while an earlier response still waits in the output register.
  assign req.ready      = (state == gha_pkg::S_IDLE) && !rst;
  assign accept         = req.valid && req.ready;
  assign exec_go        = (state == gha_pkg::S_EXEC) && (!out_valid || rsp.ready);
  assign rsp.valid      = out_valid;
  assign rsp.handle_out = out_handle;
  assign rsp.status     = out_status;

  // A close reads the slot it names; an open reads the head of the free list.
  assign slot_re    = accept;
  assign slot_raddr = (req.action == gha_pkg::ACT_CLOSE) ? req_idx : free_head;

  // Writes happen only in the committing cycle. A freed slot keeps its bumped
  // generation and is marked not live; a reopened slot is marked live.
  assign slot_we    = exec_go && ctl.slot_we;
  assign slot_waddr = wr_idx;
  assign slot_wdata = (op_action == gha_pkg::ACT_OPEN) ? {1'b1, wr_gen, op_payload}
                                                       : {1'b0, wr_gen, {PAYLOAD_BITS{1'b0}}};
  // The successor of the old tail is only written when the list was not empty.
  assign link_we    = exec_go && ctl.push && (free_tail != INVALID);

  // The tail's link is never written, so a single-entry list empties by compare.
  assign pop_head = (free_head == free_tail) ? INVALID : link_rdata;
  assign new_hext = {{gha_pkg::HANDLE_W{1'b0}}, wr_gen, wr_idx};

  always_comb begin
    state_next = state;
    case (state)
      gha_pkg::S_IDLE: begin
        if (accept) begin
          state_next = gha_pkg::S_EXEC;
        end
      end
      gha_pkg::S_EXEC: begin
        if (exec_go) begin
          state_next = gha_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gha_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_action  <= req.action;
      op_payload <= req_pext[PAYLOAD_BITS-1:0];
      op_idx     <= req_idx;
      op_gen     <= req_gen;
    end
  end

  // Free-list and slot-count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      free_head  <= INVALID;
      free_tail  <= INVALID;
    end else if (exec_go) begin
      if (ctl.append) begin
        slot_count <= slot_count + INDEX_BITS'(1);
      end
      if (ctl.pop) begin
        free_head <= pop_head;
        if (pop_head == INVALID) begin
          free_tail <= INVALID;
        end
      end
      if (ctl.push) begin
        free_tail <= op_idx;
        if (free_head == INVALID) begin
          free_head <= op_idx;
        end
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status <= ctl.status;
      out_handle <= (ctl.status == gha_pkg::ST_OPENED) ? new_hext[gha_pkg::HANDLE_W-1:0]
                                                       : '0;
    end
  end

  `GHA_ASSERT_NEXT(a_accept_to_exec, clk, rst, accept, state == gha_pkg::S_EXEC, "accepted request did not enter execute")
  `GHA_ASSERT_NOW(a_list_ends_agree, clk, rst, free_head == INVALID, free_tail == INVALID, "free-list head and tail disagree on empty")
  `GHA_ASSERT_NOW(a_head_in_range, clk, rst, free_head != INVALID, free_head < slot_count, "free-list head beyond slot count")
  `GHA_ASSERT_NOW(a_write_in_exec, clk, rst, slot_we || link_we, exec_go, "table written outside commit cycle")
  `GHA_ASSERT_NOW(a_zero_handle, clk, rst, out_valid && (out_status != gha_pkg::ST_OPENED), out_handle == '0, "nonzero handle on non-open response")

endmodule
